>>> sv/cas_pkg.sv
// Shared types, codes and constants of the cellular automaton smoothing block.
package cas_pkg;

  // Default line buffer depth (cells per row at most).
  localparam int unsigned DEF_MAX_WIDTH = 1024;

  // Grid height limit and row counter widths.
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned IN_ROW_W   = ROW_W + 1;

  // Reset grid size in both directions.
  localparam int unsigned RESET_SIZE = 64;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Rule mask, window wall count and reset rule.
  localparam int unsigned MASK_W  = 10;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned WIN_W   = 9;
  localparam logic [MASK_W-1:0] RESET_MASK = 10'd992;

  // Stream data width (one field padded to a byte).
  localparam int unsigned DATA_W = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_RULE_MASK   = 2'd2
  } cfg_reg_t;

  // Input word kinds.
  typedef enum logic {
    CMD_CELL  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  // Per-word control handed from the sequencer to the window stage.
  typedef struct packed {
    logic drain;
    logic cell_wall;
    logic emit;
    logic at_top;
    logic at_bottom;
    logic at_left;
    logic at_right;
  } step_t;

endpackage

>>> sv/cas_line_buf.sv
// Two one-bit line buffers held as one two-bit wide memory with write forwarding.
module cas_line_buf #(
  parameter int unsigned MAX_WIDTH = cas_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [1:0]                   wr_data,  // bit 0: current row, bit 1: row above
  output logic [1:0]                   rd_data   // bit 0: current row, bit 1: row above
);
  import cas_pkg::*;

  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] rd_q_r;
  logic [1:0] fwd_data_r;
  logic       fwd_hit_r;

  // Memory write and registered read; a write to the address being read is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

>>> sv/cas_seq.sv
// Configuration registers and the raster counters that classify each input word.
module cas_seq #(
  parameter int unsigned MAX_WIDTH = cas_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic                             cmd,
  input  logic                             cell_wall,
  input  logic                             cfg_fire,
  input  logic [cas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cas_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             take,
  output logic [$clog2(MAX_WIDTH)-1:0]     col,
  output cas_pkg::step_t                   step,
  output logic [cas_pkg::MASK_W-1:0]       rule_mask
);
  import cas_pkg::*;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned RESET_W = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
  localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(RESET_W - 1);
  localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(RESET_SIZE - 1);

  logic [COL_W-1:0]    w_last_r, w_last_nxt;
  logic [ROW_W-1:0]    h_last_r, h_last_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic                frame_in;
  logic                col_wrap;
  logic                eof;
  logic [31:0]         w_val;
  logic [31:0]         h_val;

  // Classify the word against the input position.
  always_comb begin
    frame_in = in_row_r > IN_ROW_W'(h_last_r);
    take     = in_fire && ((cmd == CMD_DRAIN) == frame_in);
    col      = (in_col_r > w_last_r) ? '0 : in_col_r;
    col_wrap = (col == w_last_r);

    step.drain     = (cmd == CMD_DRAIN);
    step.cell_wall = cell_wall;
    step.emit      = (in_row_r >= IN_ROW_W'(2)) ||
                     ((in_row_r == IN_ROW_W'(1)) && (col != '0));
    step.at_top    = (out_row_r == '0);
    step.at_bottom = (out_row_r == h_last_r);
    step.at_left   = (out_col_r == '0);
    step.at_right  = (out_col_r == w_last_r);
    eof            = step.at_right && step.at_bottom;
  end

  // Clamp written grid sizes to their legal range.
  always_comb begin
    w_val = 32'(cfg_data);
    if (w_val == 32'd0) begin
      w_val = 32'd1;
    end
    if (w_val > MAX_WIDTH) begin
      w_val = MAX_WIDTH;
    end
    h_val = 32'(cfg_data);
    if (h_val == 32'd0) begin
      h_val = 32'd1;
    end
    if (h_val > MAX_HEIGHT) begin
      h_val = MAX_HEIGHT;
    end
  end

  // Counter and register updates; the frame's last result restarts all counters.
  always_comb begin
    w_last_nxt  = w_last_r;
    h_last_nxt  = h_last_r;
    mask_nxt    = mask_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    if (take) begin
      in_col_nxt = col_wrap ? '0 : col + 1'b1;
      in_row_nxt = col_wrap ? in_row_r + 1'b1 : in_row_r;
      if (step.emit) begin
        if (eof) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (step.at_right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end

    if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH: begin
          w_last_nxt  = COL_W'(w_val - 32'd1);
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_GRID_HEIGHT: begin
          h_last_nxt  = ROW_W'(h_val - 32'd1);
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_RULE_MASK: begin
          mask_nxt = cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= W_LAST_RST;
      h_last_r  <= H_LAST_RST;
      mask_r    <= RESET_MASK;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      w_last_r  <= w_last_nxt;
      h_last_r  <= h_last_nxt;
      mask_r    <= mask_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign rule_mask = mask_r;

endmodule

>>> sv/cas_window.sv
// 3x3 window register, border-aware wall count and rule lookup.
module cas_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  cas_pkg::step_t              step,
  input  logic                        top,
  input  logic                        mid,
  input  logic [cas_pkg::MASK_W-1:0]  rule_mask,
  output logic                        wall
);
  import cas_pkg::*;

  logic [WIN_W-1:0]   window_r, window_nxt;
  logic [WIN_W-1:0]   oob;
  logic [WIN_W-1:0]   cells;
  logic [COUNT_W-1:0] count;
  logic               bot;

  // Shift the newest column in; bits 0..2 are the oldest column, top row first.
  always_comb begin
    bot        = step.drain ? 1'b0 : step.cell_wall;
    window_nxt = {bot, mid, top, window_r[WIN_W-1:3]};
  end

  // Positions outside the grid count as walls.
  always_comb begin
    oob = '0;
    if (step.at_left) begin
      oob[2:0] = 3'b111;
    end
    if (step.at_right) begin
      oob[8:6] = 3'b111;
    end
    if (step.at_top) begin
      oob[0] = 1'b1;
      oob[3] = 1'b1;
      oob[6] = 1'b1;
    end
    if (step.at_bottom) begin
      oob[2] = 1'b1;
      oob[5] = 1'b1;
      oob[8] = 1'b1;
    end
    cells = window_nxt | oob;
    count = '0;
    for (int i = 0; i < WIN_W; i++) begin
      count = count + COUNT_W'(cells[i]);
    end
    wall = rule_mask[count];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (advance) begin
      window_r <= window_nxt;
    end
  end

endmodule

>>> sv/cellular_automaton_smoothing.sv
// Top level: one smoothing pass of a binary 3x3 cellular automaton over a raster stream.
// Throughput: one word per cycle when the output is not back-pressured, set by the single
//   read and single write of the line buffer memory in each cycle. The word that completes
//   a result's window passes the stage register, and the result then the output register;
//   that word comes grid_width+1 words after the result's own cell.
// Reset: grid 64 x 64, rule mask 992, counters and window cleared; line buffers keep
//   their contents and need no clearing pass.
module cellular_automaton_smoothing #(
  parameter int unsigned MAX_WIDTH = cas_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cas_pkg::DATA_W-1:0]     in_tdata,   // bit 0: cell_wall, rest zero
  input  logic [0:0]                     in_tuser,   // bit 0: cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cas_pkg::DATA_W-1:0]     out_tdata,  // bit 0: out_wall, rest zero
  output logic                           out_tlast,  // end_of_row
  output logic [0:0]                     out_tuser,  // bit 0: end_of_frame
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cas_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic              adv;
  logic              in_fire;
  logic              a_fire;
  logic              cfg_fire;
  logic              take;
  logic [COL_W-1:0]  col;
  step_t             step;
  logic [MASK_W-1:0] rule_mask;
  logic              a_valid_r;
  step_t             a_step_r;
  logic [COL_W-1:0]  a_col_r;
  logic [1:0]        lb_rd;
  logic              wall;
  logic              out_valid_r;
  logic              out_wall_r;
  logic              out_eor_r;
  logic              out_eof_r;

  // Handshakes: the stage register moves whenever the output register is free.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !a_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign a_fire    = a_valid_r && adv;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  cas_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .cmd       (in_tuser[0]),
    .cell_wall (in_tdata[0]),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .col       (col),
    .step      (step),
    .rule_mask (rule_mask)
  );

  cas_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col),
    .wr_en   (a_fire && !a_step_r.drain),
    .wr_addr (a_col_r),
    .wr_data ({lb_rd[0], a_step_r.cell_wall}),
    .rd_data (lb_rd)
  );

  cas_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (a_fire),
    .step      (a_step_r),
    .top       (lb_rd[1]),
    .mid       (lb_rd[0]),
    .rule_mask (rule_mask),
    .wall      (wall)
  );

  // Stage register: a word that the sequencer ignores leaves no entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= take;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_step_r <= step;
      a_col_r  <= col;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire && a_step_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_step_r.emit) begin
      out_wall_r <= wall;
      out_eor_r  <= a_step_r.at_right;
      out_eof_r  <= a_step_r.at_right && a_step_r.at_bottom;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(DATA_W-1){1'b0}}, out_wall_r};
  assign out_tlast    = out_eor_r;
  assign out_tuser[0] = out_eof_r;

  // The last cell of the grid is always the last cell of a row.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("end of frame without end of row");

  // A stalled stage entry keeps its place and its column.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !adv |=> a_valid_r && $stable(a_col_r))
    else $error("stage entry lost while stalled");

  // The word after a frame's last result starts a new frame and cannot give a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_step_r.emit && a_step_r.at_right && a_step_r.at_bottom
      |=> !a_valid_r || !a_step_r.emit)
    else $error("result issued right after end of frame");

endmodule
